/* rtl/core/aabbt_pkg.sv */
`timescale 1ns / 1ps

package aabbt_pkg;

  // number of box corners, one cell each
  localparam int NUM_CORNERS = 8;
  localparam int NUM_AXES    = 3;
  localparam int COORD_W     = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_REGS    = 6;

  // full-precision widths of one coordinate computation
  localparam int PROD_W = 2 * COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int TOT_W  = SUM_W - 16 + 1;

  // register reset values, identity matrix
  localparam logic [CFG_DATA_W-1:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5
  } cfg_reg_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one matrix row: cols 0..2 and translation in col 3
  typedef coord_t [3:0] mrow_t;
  typedef mrow_t [NUM_AXES-1:0] matrix_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    coord_t out_min_x;
    coord_t out_min_y;
    coord_t out_min_z;
    coord_t out_max_x;
    coord_t out_max_y;
    coord_t out_max_z;
    logic   saturated;
  } result_t;

  // running min / max carried along the chain
  typedef struct packed {
    coord_t [NUM_AXES-1:0] mn;
    coord_t [NUM_AXES-1:0] mx;
    logic                  sat;
  } acc_t;

  // what one cell hands to the next
  typedef struct packed {
    box_t box;
    acc_t acc;
  } link_t;

endpackage

/* rtl/core/aabbt_regs.sv */
`timescale 1ns / 1ps

module aabbt_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [aabbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aabbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output aabbt_pkg::matrix_t               mat
);
  import aabbt_pkg::*;

  logic [NUM_REGS-1:0][CFG_DATA_W-1:0] regs;

  // register write, out-of-range indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_ROW0_COLS01] <= RST_ROW0_COLS01;
      regs[REG_ROW0_COLS23] <= RST_ROW0_COLS23;
      regs[REG_ROW1_COLS01] <= RST_ROW1_COLS01;
      regs[REG_ROW1_COLS23] <= RST_ROW1_COLS23;
      regs[REG_ROW2_COLS01] <= RST_ROW2_COLS01;
      regs[REG_ROW2_COLS23] <= RST_ROW2_COLS23;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_ROW0_COLS01: regs[REG_ROW0_COLS01] <= cfg_wdata;
        REG_ROW0_COLS23: regs[REG_ROW0_COLS23] <= cfg_wdata;
        REG_ROW1_COLS01: regs[REG_ROW1_COLS01] <= cfg_wdata;
        REG_ROW1_COLS23: regs[REG_ROW1_COLS23] <= cfg_wdata;
        REG_ROW2_COLS01: regs[REG_ROW2_COLS01] <= cfg_wdata;
        REG_ROW2_COLS23: regs[REG_ROW2_COLS23] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack the two q16.16 halves of each register
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      mat[r][0] = coord_t'(regs[2*r][COORD_W-1:0]);
      mat[r][1] = coord_t'(regs[2*r][CFG_DATA_W-1:COORD_W]);
      mat[r][2] = coord_t'(regs[2*r+1][COORD_W-1:0]);
      mat[r][3] = coord_t'(regs[2*r+1][CFG_DATA_W-1:COORD_W]);
    end
  end

endmodule

/* rtl/core/aabbt_cell.sv */
`timescale 1ns / 1ps

module aabbt_cell #(
  parameter int CORNER = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  aabbt_pkg::matrix_t  mat,
  input  logic                in_valid,
  output logic                in_ready,
  input  aabbt_pkg::link_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aabbt_pkg::link_t    out_data
);
  import aabbt_pkg::*;

  localparam logic [2:0] SEL   = 3'(CORNER);
  localparam bit         FIRST = (CORNER == 0);

  coord_t [NUM_AXES-1:0]        vec;
  logic signed [PROD_W-1:0]     prod_d [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0]     prod_q [NUM_AXES][NUM_AXES];
  logic                         v1, v2, v3;
  logic                         rdy1, rdy2, rdy3;
  box_t                         box1, box2;
  acc_t                         acc1, acc2, acc_d, acc3;
  box_t                         box3;
  logic signed [SUM_W-1:0]      sum  [NUM_AXES];
  logic signed [SUM_W-1:0]      rnd  [NUM_AXES];
  logic signed [TOT_W-1:0]      tot  [NUM_AXES];
  coord_t [NUM_AXES-1:0]        coord_d, coord_q;
  logic [NUM_AXES-1:0]          sat_d;
  logic                         sat_q;

  // stage readiness, a bubble lets upstream move on
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // pick this cell's corner
  always_comb begin
    vec[0] = SEL[2] ? in_data.box.max_x : in_data.box.min_x;
    vec[1] = SEL[1] ? in_data.box.max_y : in_data.box.min_y;
    vec[2] = SEL[0] ? in_data.box.max_z : in_data.box.min_z;
  end

  // exact q32.32 products
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        prod_d[r][c] = PROD_W'($signed(mat[r][c])) * PROD_W'($signed(vec[c]));
      end
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod_q <= prod_d;
      box1   <= in_data.box;
      acc1   <= in_data.acc;
    end
  end

  // sum, round half up, add translation, clamp
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      sum[r] = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]);
      rnd[r] = sum[r] + SUM_W'(32768);
      tot[r] = TOT_W'(rnd[r] >>> 16) + TOT_W'($signed(mat[r][3]));
      if (tot[r] > TOT_W'(64'sh7fff_ffff)) begin
        coord_d[r] = {1'b0, {(COORD_W-1){1'b1}}};
        sat_d[r]   = 1'b1;
      end else if (tot[r] < -TOT_W'(64'sh8000_0000)) begin
        coord_d[r] = {1'b1, {(COORD_W-1){1'b0}}};
        sat_d[r]   = 1'b1;
      end else begin
        coord_d[r] = tot[r][COORD_W-1:0];
        sat_d[r]   = 1'b0;
      end
    end
  end

  // stage 2: transformed corner
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      coord_q <= coord_d;
      sat_q   <= |sat_d;
      box2    <= box1;
      acc2    <= acc1;
    end
  end

  // fold the corner into the running min / max
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (FIRST || (coord_q[a] < acc2.mn[a])) begin
        acc_d.mn[a] = coord_q[a];
      end else begin
        acc_d.mn[a] = acc2.mn[a];
      end
      if (FIRST || (coord_q[a] > acc2.mx[a])) begin
        acc_d.mx[a] = coord_q[a];
      end else begin
        acc_d.mx[a] = acc2.mx[a];
      end
    end
    acc_d.sat = FIRST ? sat_q : (acc2.sat | sat_q);
  end

  // stage 3: output register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      box3 <= box2;
      acc3 <= acc_d;
    end
  end

  assign out_valid    = v3;
  assign out_data.box = box3;
  assign out_data.acc = acc3;

endmodule

/* rtl/core/aabb_affine_transform_top.sv */
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data  (box_t, min and max corner)
// out     | output    | out_valid / out_ready| out_data (result_t, new box and flag)
// cfg     | input     | cfg_we               | cfg_index, cfg_wdata (64-bit register)
//
// one item per cycle sustained while out_ready is high; 8 corner cells in a chain
// each cell multiplies one corner by the matrix, rounds and clamps, then folds it into
// the running min / max handed on from the previous cell
// a stall on out holds only the stages that are full; empty stages keep taking items
// rst is synchronous and clears all valid bits and loads the identity matrix

module aabb_affine_transform_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [aabbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aabbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  aabbt_pkg::box_t                  in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output aabbt_pkg::result_t               out_data
);
  import aabbt_pkg::*;

  matrix_t                   mat;
  link_t [NUM_CORNERS:0]     link;
  logic  [NUM_CORNERS:0]     link_valid;
  logic  [NUM_CORNERS:0]     link_ready;

  // matrix registers
  aabbt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mat       (mat)
  );

  // chain head: box enters with an empty accumulator
  assign link[0].box     = in_data;
  assign link[0].acc     = '0;
  assign link_valid[0]   = in_valid;
  assign in_ready        = link_ready[0];

  // one cell per corner
  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_cell
    aabbt_cell #(
      .CORNER (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .mat       (mat),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_data   (link[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_data  (link[k+1])
    );
  end

  // chain tail drives the result item
  assign link_ready[NUM_CORNERS] = out_ready;
  assign out_valid               = link_valid[NUM_CORNERS];
  assign out_data.out_min_x      = link[NUM_CORNERS].acc.mn[0];
  assign out_data.out_min_y      = link[NUM_CORNERS].acc.mn[1];
  assign out_data.out_min_z      = link[NUM_CORNERS].acc.mn[2];
  assign out_data.out_max_x      = link[NUM_CORNERS].acc.mx[0];
  assign out_data.out_max_y      = link[NUM_CORNERS].acc.mx[1];
  assign out_data.out_max_z      = link[NUM_CORNERS].acc.mx[2];
  assign out_data.saturated      = link[NUM_CORNERS].acc.sat;

  // min and max are taken over the same corners, so never cross
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_data.out_min_x) <= $signed(out_data.out_max_x) &&
                   $signed(out_data.out_min_y) <= $signed(out_data.out_max_y) &&
                   $signed(out_data.out_min_z) <= $signed(out_data.out_max_z)))
    else $error("result box min above max");

  // a free output leaves no stage blocked
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is taken");

  // no item survives reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result item present right after reset");

endmodule
